// ----- hdl/cklu_pkg.sv -----
// Package for the compacting key list unit: command and status codes.
// Used by the top level and by its checker; depends on nothing else.
package cklu_pkg;

   // Command codes carried in req_tuser.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Status codes returned in the low bits of rsp_tdata.
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_CLEARED   = 3'd4;

   localparam int STATUS_BITS = 3;
   localparam int COUNT_BITS  = 5;

endpackage

// ----- hdl/compacting_key_list_unit.sv -----
// Compacting key list: insert, remove-and-compact and clear over a slot memory; uses cklu_pkg.
// Insert, clear, an unused command and a remove that needs no scan go from S_IDLE to S_FINISH;
// a scanning remove first reads each occupied slot, then compares it or moves it down. S_FINISH
// loads the result register, waiting while a stalled result occupies it, and returns to S_IDLE.
// Reset (synchronous, active high) empties the list by clearing the fill count, not the slots;
// it also returns the sequencer to S_IDLE and clears the result valid.
module compacting_key_list_unit
   import cklu_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] key
   input  logic [1:0]  req_tuser,   // [1:0] action
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [2:0] status, [7:3] entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SRCH_RD  = 6'b000010,
      S_SRCH_CMP = 6'b000100,
      S_SHIFT_RD = 6'b001000,
      S_SHIFT_WR = 6'b010000,
      S_FINISH   = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;

   // Slot memory: one write port, one registered read port. Slots at or
   // above the fill count are empty by definition and are never read.
   logic [KEY_BITS-1:0]     slot_mem [CAPACITY];
   logic [KEY_BITS-1:0]     rd_data_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [KEY_BITS-1:0]     mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;

   logic                    req_fire;
   logic [KEY_BITS-1:0]     req_key;
   logic [IDX_W-1:0]        ptr_next;
   logic [CNT_W-1:0]        count_last;
   logic                    rsp_load_ok;
   logic [CNT_W+COUNT_BITS-1:0] count_wide;

   // One command is processed at a time; req_tready is high only while the
   // sequencer is idle, and a new command may be taken while the previous
   // result still waits in the output register.
   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign req_key     = req_tdata[KEY_BITS-1:0];
   assign ptr_next    = ptr_ff + IDX_W'(1);
   assign count_last  = count_ff - CNT_W'(1);
   assign rsp_load_ok = !rsp_valid_ff || rsp_tready;

   // entry_count is the fill count masked to five bits.
   assign count_wide = {{COUNT_BITS{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in   = req_key;
               ptr_in   = '0;
               state_in = S_FINISH;
               priority if (req_tuser == ACT_INSERT) begin
                  if (count_ff == CAP_COUNT) begin
                     status_in = ST_FULL;
                  end else begin
                     // The empty key leaves the list as it is.
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[IDX_W-1:0];
                     mem_wdata = req_key;
                     if (req_key != '0) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     status_in = ST_INSERTED;
                  end
               end else if (req_tuser == ACT_REMOVE) begin
                  if (req_key == '0) begin
                     // The empty key matches the first empty slot, if any.
                     status_in = (count_ff == CAP_COUNT) ? ST_NOT_FOUND : ST_REMOVED;
                  end else if (count_ff == '0) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end else if (req_tuser == ACT_CLEAR) begin
                  count_in  = '0;
                  status_in = ST_CLEARED;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end
         S_SRCH_RD: begin
            mem_raddr = ptr_ff;
            state_in  = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (rd_data_ff == key_ff) begin
               if (CNT_W'(ptr_ff) == count_last) begin
                  // Match in the last occupied slot: nothing to move.
                  count_in  = count_last;
                  status_in = ST_REMOVED;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (CNT_W'(ptr_ff) == count_last) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               ptr_in   = ptr_next;
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            mem_raddr = ptr_next;
            state_in  = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data_ff;
            if (CNT_W'(ptr_next) == count_last) begin
               count_in  = count_last;
               status_in = ST_REMOVED;
               state_in  = S_FINISH;
            end else begin
               ptr_in   = ptr_next;
               state_in = S_SHIFT_RD;
            end
         end
         S_FINISH: begin
            if (rsp_load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_wide[COUNT_BITS-1:0], status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/cklu_checker.sv -----
// Port-level checks for the compacting key list unit, bound to its top level.
// Depends on cklu_pkg and on compacting_key_list_unit.
module cklu_checker
   import cklu_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   localparam logic [COUNT_BITS-1:0] CAP_MASKED = COUNT_BITS'(CAPACITY);

   // Commands are processed one at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("cklu: command taken while the previous one is in progress");

   // A clear always leaves an empty list.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == ST_CLEARED) |-> (rsp_tdata[7:3] == '0))
      else $error("cklu: clear reported a nonzero count");

   // A full report comes only with every slot occupied.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == ST_FULL) |-> (rsp_tdata[7:3] == CAP_MASKED))
      else $error("cklu: list full reported below capacity");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("cklu: stalled result changed or was dropped");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("cklu: result valid right after reset");

endmodule

bind compacting_key_list_unit cklu_checker #(.CAPACITY(CAPACITY)) u_cklu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/tb_compacting_key_list_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for compacting_key_list_unit: a directed table of commands and
// then random insert/remove/clear traffic, checked against a shadow copy of the key list.
// Depends on cklu_pkg and the compacting_key_list_unit RTL only.
module tb_compacting_key_list_unit;
   import cklu_pkg::*;

   localparam int LIST_SLOTS = 16;
   localparam int KEY_BITS = 64;
   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [63:0] ALL_ONES = {64{1'b1}};
   localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
   localparam int ITEMS_PER_PHASE = 410;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 2 * LIST_SLOTS + 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;
   localparam int DIRECTED_ROWS = 26;

   // Result layout, lowest bits first: status in [2:0], count in [7:3].
   typedef struct packed {
      logic [4:0] count;
      logic [2:0] status;
   } list_reply_type;

   // Result fixed by hand for a directed row, or left to the shadow list.
   typedef struct packed {
      logic fixed;
      list_reply_type reply;
   } typed_reply_type;

   typedef struct packed {
      logic [1:0] action;
      logic [63:0] key;
      logic fixed;
      logic [2:0] status;
      logic [4:0] count;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0] req_tuser = ACT_INSERT;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   // Shadow of the list held by the block, updated on every accepted command.
   logic [63:0] shadow_keys [LIST_SLOTS];
   int shadow_fill = 0;

   list_reply_type pending_replies [$];
   typed_reply_type typed_replies [$];

   int unsigned send_idle_pct = 7;
   int unsigned recv_idle_pct = 66;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int failures = 0;
   int commands_accepted = 0;
   int replies_checked = 0;
   int replies_by_status [5] = '{0, 0, 0, 0, 0};
   int cycle_count = 0;
   logic filling = 1'b0;
   int mode_left = 0;
   logic [63:0] hot_keys [8];

   // Directed commands. Rows with the fixed flag carry a result that is plain from the
   // list contents; the run of inserts that fills the list is left to the shadow list.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_REMOVE, 64'd5, 1'b1, ST_NOT_FOUND, 5'd0},
      '{ACT_UNUSED, 64'd0, 1'b1, ST_NOT_FOUND, 5'd0},
      '{ACT_INSERT, 64'd0, 1'b1, ST_INSERTED, 5'd0},
      '{ACT_REMOVE, 64'd0, 1'b1, ST_REMOVED, 5'd0},
      '{ACT_INSERT, ALL_ONES, 1'b1, ST_INSERTED, 5'd1},
      '{ACT_INSERT, 64'd1, 1'b1, ST_INSERTED, 5'd2},
      '{ACT_INSERT, TOP_BIT, 1'b1, ST_INSERTED, 5'd3},
      '{ACT_REMOVE, 64'd1, 1'b1, ST_REMOVED, 5'd2},
      '{ACT_INSERT, 64'h5555_5555_5555_5555, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, TOP_BIT, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd3, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd4, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd5, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd6, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd7, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd8, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd9, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd10, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd11, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd12, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd13, 1'b0, ST_INSERTED, 5'd0},
      '{ACT_INSERT, 64'd7, 1'b1, ST_FULL, 5'd16},
      '{ACT_REMOVE, 64'd0, 1'b1, ST_NOT_FOUND, 5'd16},
      '{ACT_REMOVE, ALL_ONES, 1'b1, ST_REMOVED, 5'd15},
      '{ACT_CLEAR, 64'h1234_5678_9ABC_DEF0, 1'b1, ST_CLEARED, 5'd0}
   };

   compacting_key_list_unit #(
      .CAPACITY (LIST_SLOTS),
      .KEY_BITS (KEY_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [63:0] key
      .req_tuser  (req_tuser),    // [1:0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [2:0] status, [7:3] entry_count
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int first_free_slot();
      int i;
      i = 0;
      while (i < LIST_SLOTS && shadow_keys[i] != '0) i++;
      return i;
   endfunction

   // Applies one command to the shadow list and returns the reply it should cause.
   function automatic list_reply_type shadow_list_step(input logic [1:0] act,
                                                       input logic [63:0] raw_key);
      logic [63:0] k;
      logic [2:0] st;
      int i;
      k = raw_key & KEY_MASK;
      unique case (act)
         ACT_INSERT: begin
            i = first_free_slot();
            if (i == LIST_SLOTS) begin
               st = ST_FULL;
            end else begin
               shadow_keys[i] = k;
               st = ST_INSERTED;
            end
         end
         ACT_REMOVE: begin
            // The search stops at the first empty slot, so a zero key matches there.
            i = 0;
            while (i < LIST_SLOTS && shadow_keys[i] != '0 && shadow_keys[i] != k) i++;
            if (i == LIST_SLOTS || shadow_keys[i] != k) begin
               st = ST_NOT_FOUND;
            end else begin
               while (i < LIST_SLOTS - 1 && shadow_keys[i] != '0) begin
                  shadow_keys[i] = shadow_keys[i + 1];
                  i++;
               end
               shadow_keys[LIST_SLOTS - 1] = '0;
               st = ST_REMOVED;
            end
         end
         ACT_CLEAR: begin
            for (i = 0; i < LIST_SLOTS; i++) shadow_keys[i] = '0;
            st = ST_CLEARED;
         end
         default: st = ST_NOT_FOUND;
      endcase
      shadow_fill = first_free_slot();
      return '{count: 5'(shadow_fill), status: st};
   endfunction

   task automatic report_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Watches both channels. Predictions are made as a command transaction is accepted;
   // each reply transaction is checked against the oldest prediction.
   always @(posedge clock) begin : watch_channels
      list_reply_type predicted;
      list_reply_type got;
      list_reply_type want;
      typed_reply_type typed;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted = shadow_list_step(req_tuser, req_tdata);
            typed = '0;
            if (typed_replies.size() != 0) typed = typed_replies.pop_front();
            pending_replies.push_back(typed.fixed ? typed.reply : predicted);
            commands_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (got.status <= ST_CLEARED) replies_by_status[got.status]++;
            if (pending_replies.size() == 0) begin
               report_failure($sformatf("unexpected reply status %0d count %0d",
                                        got.status, got.count));
            end else begin
               want = pending_replies.pop_front();
               replies_checked++;
               if (got.status !== want.status || got.count !== want.count)
                  report_failure($sformatf(
                     "reply mismatch: expected status %0d count %0d, got status %0d count %0d",
                     want.status, want.count, got.status, got.count));
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off whenever the sender asks for one.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Offers one command transaction and returns at the edge where it is accepted.
   task automatic send_command(input logic [1:0] act, input logic [63:0] key,
                               input typed_reply_type typed);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      typed_replies.push_back(typed);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= key;
      req_tuser <= act;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Random traffic alternates between filling and draining stretches so that the list
   // reaches full and empty often; removes mostly name a key that is in the list.
   task automatic pick_command(output logic [1:0] act, output logic [63:0] key);
      int unsigned roll;
      int unsigned insert_pct;
      if (mode_left == 0) begin
         filling = !filling;
         mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      insert_pct = filling ? 75 : 30;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) act = ACT_INSERT;
      else if (roll < 96) act = ACT_REMOVE;
      else if (roll < 98) act = ACT_CLEAR;
      else act = ACT_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 6) key = '0;
      else if (act == ACT_REMOVE && roll < 70 && shadow_fill != 0)
         key = shadow_keys[$urandom_range(0, shadow_fill - 1)];
      else if (roll < 35) key = hot_keys[$urandom_range(0, 7)];
      else key = {$urandom, $urandom};
   endtask

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) break;
      end
      $display("Timeout after %0d cycles with %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned send_pcts [3] = '{7, 66, 0};
      int unsigned recv_pcts [3] = '{66, 7, 0};
      logic [1:0] act;
      logic [63:0] key;
      typed_reply_type typed;
      for (int i = 0; i < LIST_SLOTS; i++) shadow_keys[i] = '0;
      for (int i = 0; i < 8; i++) hot_keys[i] = {$urandom, $urandom};
      hot_keys[0] = ALL_ONES;
      hot_keys[1] = 64'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         recv_idle_pct = recv_pcts[phase];
         if (phase == 0) begin
            foreach (directed_rows[r]) begin
               typed.fixed = directed_rows[r].fixed;
               typed.reply = '{count: directed_rows[r].count, status: directed_rows[r].status};
               send_command(directed_rows[r].action, directed_rows[r].key, typed);
            end
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Early on, stop the result side for a long while so the block backs up.
            if (phase == 0 && n == 60) hold_requests <= hold_requests + 1;
            pick_command(act, key);
            send_command(act, key, '0);
         end
         // The sender pauses here until every reply of the phase is back.
         wait_for_replies();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_replies.size() != 0)
         report_failure($sformatf("%0d replies never arrived", pending_replies.size()));

      $display("Run covered %0d commands (%0d directed) and %0d checked replies.",
               commands_accepted, DIRECTED_ROWS, replies_checked);
      $display("Replies: %0d inserted, %0d full, %0d removed, %0d not found, %0d cleared.",
               replies_by_status[ST_INSERTED], replies_by_status[ST_FULL],
               replies_by_status[ST_REMOVED], replies_by_status[ST_NOT_FOUND],
               replies_by_status[ST_CLEARED]);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d failures", failures);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
